FILE: src/mra_pkg.sv
`timescale 1ns / 1ps
package mra_pkg;
   localparam int DefaultWidth = 32;
   localparam int FieldWidth = 32;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      FAULT_NONE = 2'd0,
      FAULT_DIV_ZERO = 2'd1,
      FAULT_DEN_WRAP = 2'd2
   } fault_type;

   // operation code from the sequencer to the shared datapath
   typedef enum logic [1:0] {
      DP_MUL = 2'd0,
      DP_DIV = 2'd1,
      DP_GCD = 2'd2
   } dp_op_type;
endpackage

FILE: src/mra_alu.sv
`timescale 1ns / 1ps
// Shared multi-cycle unit: shift-add multiply (low WIDTH bits and full
// 2*WIDTH product), restoring divide, binary GCD. One bit/step per cycle.
module mra_alu
   import mra_pkg::*;
#(
   parameter int WIDTH = DefaultWidth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  dp_op_type        op,
   input  logic [WIDTH-1:0] x,
   input  logic [WIDTH-1:0] y,
   output logic             done,
   output logic [2*WIDTH-1:0] prod,
   output logic [WIDTH-1:0] quot,
   output logic [WIDTH-1:0] rem,
   output logic [WIDTH-1:0] gcd
);
   localparam int CW = $clog2(2*WIDTH+1);

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_DIV, S_GCD_PRE, S_GCD, S_DONE
   } state_type;

   state_type        state_ff;
   logic [CW-1:0]    cnt_ff;
   logic [2*WIDTH-1:0] acc_ff;
   logic [2*WIDTH-1:0] mcand_ff;
   logic [WIDTH-1:0] mplier_ff;
   logic [WIDTH-1:0] u_ff, v_ff;
   logic [CW-1:0]    k_ff;
   logic [WIDTH:0]   r_ff;

   logic [WIDTH:0]   r_shift;
   logic [WIDTH:0]   r_trial;

   always_comb begin
      r_shift = {r_ff[WIDTH-1:0], mplier_ff[WIDTH-1]};
      r_trial = r_shift - {1'b0, y};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  cnt_ff <= '0;
                  acc_ff <= '0;
                  mcand_ff <= {{WIDTH{1'b0}}, x};
                  mplier_ff <= (op == DP_MUL) ? y : x;
                  r_ff <= '0;
                  u_ff <= x;
                  v_ff <= y;
                  k_ff <= '0;
                  unique case (op)
                     DP_MUL:  state_ff <= S_MUL;
                     DP_DIV:  state_ff <= S_DIV;
                     default: state_ff <= S_GCD_PRE;
                  endcase
               end
            end
            S_MUL: begin
               if (mplier_ff[0]) acc_ff <= acc_ff + mcand_ff;
               mcand_ff <= mcand_ff << 1;
               mplier_ff <= mplier_ff >> 1;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CW'(WIDTH-1)) state_ff <= S_DONE;
            end
            S_DIV: begin
               // mplier_ff holds the dividend, shifted left; quotient bits enter at the bottom
               if (!r_trial[WIDTH]) begin
                  r_ff <= r_trial;
                  mplier_ff <= {mplier_ff[WIDTH-2:0], 1'b1};
               end else begin
                  r_ff <= r_shift;
                  mplier_ff <= {mplier_ff[WIDTH-2:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CW'(WIDTH-1)) state_ff <= S_DONE;
            end
            S_GCD_PRE: begin
               if (u_ff == '0) begin
                  u_ff <= v_ff;
                  state_ff <= S_DONE;
               end else if (v_ff == '0) begin
                  state_ff <= S_DONE;
               end else if (!u_ff[0] && !v_ff[0]) begin
                  u_ff <= u_ff >> 1;
                  v_ff <= v_ff >> 1;
                  k_ff <= k_ff + 1'b1;
               end else begin
                  state_ff <= S_GCD;
               end
            end
            S_GCD: begin
               if (u_ff == '0) begin
                  u_ff <= v_ff << k_ff;
                  state_ff <= S_DONE;
               end else if (!u_ff[0]) begin
                  u_ff <= u_ff >> 1;
               end else if (!v_ff[0]) begin
                  v_ff <= v_ff >> 1;
               end else if (u_ff >= v_ff) begin
                  u_ff <= (u_ff - v_ff) >> 1;
               end else begin
                  v_ff <= (v_ff - u_ff) >> 1;
               end
            end
            S_DONE: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign done = (state_ff == S_DONE);
   assign prod = acc_ff;
   assign quot = mplier_ff;
   assign rem  = r_ff[WIDTH-1:0];
   assign gcd  = u_ff;
endmodule

FILE: src/mixed_rational_arith_unit_core.sv
`timescale 1ns / 1ps
// Mixed-number arithmetic unit: two signed mixed numbers (sign, whole,
// proper fraction) and an operation (add, subtract, multiply, divide) in,
// one result out as sign, whole and binary-GCD-reduced fraction plus a
// fault code.
// Input channel req_*: valid/ready; req_ready is high only while the block
// is idle, one item in flight at a time.
// Result channel rsp_*: valid/ready; the result is held in an output
// register until transferred. A new request is taken in the same cycle the
// result transfers.
// Datapath: every multiply and divide runs on one shared shift-add /
// restoring-divide / binary-GCD unit, one bit per cycle. An item needs at
// most 8 multiplies, 9 divisions and 3 GCDs; faulting items finish sooner.
// Reset: synchronous, active high; clears the sequencer and rsp_valid.
// Stall: while a result is pending and rsp_ready is low the result holds and no request is taken.
module mixed_rational_arith_unit_core
   import mra_pkg::*;
#(
   parameter int WIDTH = DefaultWidth
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_operation,
   input  logic                  req_a_positive,
   input  logic [FieldWidth-1:0] req_a_integer_part,
   input  logic [FieldWidth-1:0] req_a_frac_top,
   input  logic [FieldWidth-1:0] req_a_frac_bottom,
   input  logic                  req_b_positive,
   input  logic [FieldWidth-1:0] req_b_integer_part,
   input  logic [FieldWidth-1:0] req_b_frac_top,
   input  logic [FieldWidth-1:0] req_b_frac_bottom,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_r_positive,
   output logic [FieldWidth-1:0] rsp_r_integer_part,
   output logic [FieldWidth-1:0] rsp_r_frac_top,
   output logic [FieldWidth-1:0] rsp_r_frac_bottom,
   output logic [1:0]            rsp_fault
);
   localparam int W = WIDTH;

   typedef logic [W-1:0] word_type;

   // Sequencer steps. N* = normalise (div, gcd, two divs by g)
   typedef enum logic [5:0] {
      P_IDLE,
      P_NA_DIV, P_NA_GCD, P_NA_DN, P_NA_DD,
      P_NB_DIV, P_NB_GCD, P_NB_DN, P_NB_DD,
      P_PREP,
      P_RC_M, P_RC_FIN,
      P_OP,
      P_AS_D, P_AS_N1, P_AS_N2, P_AS_FIN,
      P_SB_C1, P_SB_C2, P_SB_CMP, P_SB_B1, P_SB_B2, P_SB_BCMP,
      P_SB_D, P_SB_X, P_SB_Y, P_SB_FIN,
      P_M_W, P_M_T1, P_M_T2, P_M_T3, P_M_T4, P_M_T5, P_M_D, P_M_FIN,
      P_NR_CHK, P_NR_DIV, P_NR_GCD, P_NR_DN, P_NR_DD,
      P_WAIT,
      P_DONE
   } state_type;

   state_type   state_ff, ret_ff;
   logic [1:0]  op_ff;
   logic        ap_ff, bp_ff, rp_ff;
   word_type    aw_ff, an_ff, ad_ff, bw_ff, bn_ff, bd_ff;
   word_type    rw_ff, rn_ff, rd_ff;
   word_type    t_ff, u_ff, g_ff;
   logic [2*W-1:0] p1_ff;
   logic [1:0]  fault_ff;
   logic        big_a_ff;

   // shared unit
   logic        alu_start;
   dp_op_type   alu_op;
   word_type    alu_x, alu_y;
   logic        alu_done;
   logic [2*W-1:0] alu_prod;
   word_type    alu_quot, alu_rem, alu_gcd;

   logic        alu_start_ff;
   dp_op_type   alu_op_ff;
   word_type    alu_x_ff, alu_y_ff;

   assign alu_start = alu_start_ff;
   assign alu_op = alu_op_ff;
   assign alu_x = alu_x_ff;
   assign alu_y = alu_y_ff;

   mra_alu #(.WIDTH(W)) u_alu (
      .clock (clock),
      .reset (reset),
      .start (alu_start),
      .op    (alu_op),
      .x     (alu_x),
      .y     (alu_y),
      .done  (alu_done),
      .prod  (alu_prod),
      .quot  (alu_quot),
      .rem   (alu_rem),
      .gcd   (alu_gcd)
   );

   word_type plo;
   assign plo = alu_prod[W-1:0];

   function automatic word_type fit(input logic [FieldWidth-1:0] v);
      logic [W+FieldWidth-1:0] t;
      t = {{W{1'b0}}, v};
      return t[W-1:0];
   endfunction

   function automatic logic [FieldWidth-1:0] out32(input word_type v);
      logic [W+FieldWidth-1:0] t;
      t = {{FieldWidth{1'b0}}, v};
      return t[FieldWidth-1:0];
   endfunction

   assign req_ready = (state_ff == P_IDLE) && (!rsp_valid || rsp_ready);

   // every start is followed by P_WAIT, which drops it again
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= P_IDLE;
         rsp_valid <= 1'b0;
         alu_start_ff <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
         unique case (state_ff)
            P_IDLE: begin
               if (req_valid && req_ready) begin
                  op_ff <= req_operation;
                  ap_ff <= req_a_positive;
                  aw_ff <= fit(req_a_integer_part);
                  an_ff <= fit(req_a_frac_top);
                  ad_ff <= fit(req_a_frac_bottom);
                  bp_ff <= req_b_positive;
                  bw_ff <= fit(req_b_integer_part);
                  bn_ff <= fit(req_b_frac_top);
                  bd_ff <= fit(req_b_frac_bottom);
                  if (fit(req_a_frac_bottom) == '0 || fit(req_b_frac_bottom) == '0) begin
                     fault_ff <= FAULT_DIV_ZERO;
                     state_ff <= P_DONE;
                  end else begin
                     fault_ff <= FAULT_NONE;
                     alu_start_ff <= 1'b1;
                     alu_op_ff <= DP_DIV;
                     alu_x_ff <= fit(req_a_frac_top);
                     alu_y_ff <= fit(req_a_frac_bottom);
                     state_ff <= P_WAIT;
                     ret_ff <= P_NA_DIV;
                  end
               end
            end
            P_WAIT: begin
               alu_start_ff <= 1'b0;
               if (alu_done) state_ff <= ret_ff;
            end
            // ---- normalise a
            P_NA_DIV: begin
               aw_ff <= aw_ff + alu_quot;
               an_ff <= alu_rem;
               alu_start_ff <= 1'b1; alu_op_ff <= DP_GCD;
               alu_x_ff <= alu_rem; alu_y_ff <= ad_ff;
               state_ff <= P_WAIT; ret_ff <= P_NA_GCD;
            end
            P_NA_GCD: begin
               g_ff <= alu_gcd;
               if (alu_gcd > word_type'(1)) begin
                  alu_start_ff <= 1'b1; alu_op_ff <= DP_DIV;
                  alu_x_ff <= an_ff; alu_y_ff <= alu_gcd;
                  state_ff <= P_WAIT; ret_ff <= P_NA_DN;
               end else begin
                  state_ff <= P_NA_DD;
               end
            end
            P_NA_DN: begin
               an_ff <= alu_quot;
               alu_start_ff <= 1'b1; alu_op_ff <= DP_DIV;
               alu_x_ff <= ad_ff; alu_y_ff <= g_ff;
               state_ff <= P_WAIT; ret_ff <= P_NA_DD;
            end
            P_NA_DD: begin
               if (g_ff > word_type'(1)) ad_ff <= alu_quot;
               alu_start_ff <= 1'b1; alu_op_ff <= DP_DIV;
               alu_x_ff <= bn_ff; alu_y_ff <= bd_ff;
               state_ff <= P_WAIT; ret_ff <= P_NB_DIV;
            end
            // ---- normalise b
            P_NB_DIV: begin
               bw_ff <= bw_ff + alu_quot;
               bn_ff <= alu_rem;
               alu_start_ff <= 1'b1; alu_op_ff <= DP_GCD;
               alu_x_ff <= alu_rem; alu_y_ff <= bd_ff;
               state_ff <= P_WAIT; ret_ff <= P_NB_GCD;
            end
            P_NB_GCD: begin
               g_ff <= alu_gcd;
               if (alu_gcd > word_type'(1)) begin
                  alu_start_ff <= 1'b1; alu_op_ff <= DP_DIV;
                  alu_x_ff <= bn_ff; alu_y_ff <= alu_gcd;
                  state_ff <= P_WAIT; ret_ff <= P_NB_DN;
               end else begin
                  state_ff <= P_NB_DD;
               end
            end
            P_NB_DN: begin
               bn_ff <= alu_quot;
               alu_start_ff <= 1'b1; alu_op_ff <= DP_DIV;
               alu_x_ff <= bd_ff; alu_y_ff <= g_ff;
               state_ff <= P_WAIT; ret_ff <= P_NB_DD;
            end
            P_NB_DD: begin
               if (g_ff > word_type'(1)) bd_ff <= alu_quot;
               state_ff <= P_PREP;
            end
            P_PREP: begin
               if (op_ff == OP_SUB) bp_ff <= !bp_ff;
               if (op_ff == OP_DIV) begin
                  if (bw_ff == '0 && bn_ff == '0) begin
                     fault_ff <= FAULT_DIV_ZERO;
                     state_ff <= P_DONE;
                  end else begin
                     alu_start_ff <= 1'b1; alu_op_ff <= DP_MUL;
                     alu_x_ff <= bw_ff; alu_y_ff <= bd_ff;
                     state_ff <= P_WAIT; ret_ff <= P_RC_M;
                  end
               end else begin
                  state_ff <= P_OP;
               end
            end
            P_RC_M: begin
               bd_ff <= plo + bn_ff;
               bn_ff <= bd_ff;
               bw_ff <= '0;
               state_ff <= P_OP;
            end
            P_OP: begin
               alu_start_ff <= 1'b1; alu_op_ff <= DP_MUL;
               state_ff <= P_WAIT;
               if (op_ff == OP_MUL || op_ff == OP_DIV) begin
                  alu_x_ff <= aw_ff; alu_y_ff <= bw_ff;
                  ret_ff <= P_M_W;
               end else if (ap_ff == bp_ff) begin
                  alu_x_ff <= ad_ff; alu_y_ff <= bd_ff;
                  ret_ff <= P_AS_D;
               end else begin
                  alu_x_ff <= an_ff; alu_y_ff <= bd_ff;
                  ret_ff <= P_SB_C1;
               end
            end
            // ---- same-sign add
            P_AS_D: begin
               rd_ff <= plo;
               alu_start_ff <= 1'b1; alu_op_ff <= DP_MUL;
               alu_x_ff <= an_ff; alu_y_ff <= bd_ff;
               state_ff <= P_WAIT; ret_ff <= P_AS_N1;
            end
            P_AS_N1: begin
               t_ff <= plo;
               alu_start_ff <= 1'b1; alu_op_ff <= DP_MUL;
               alu_x_ff <= bn_ff; alu_y_ff <= ad_ff;
               state_ff <= P_WAIT; ret_ff <= P_AS_N2;
            end
            P_AS_N2: begin
               rp_ff <= ap_ff;
               rw_ff <= aw_ff + bw_ff;
               rn_ff <= t_ff + plo;
               state_ff <= P_NR_CHK;
            end
            // ---- opposite-sign: full products an*bd vs bn*ad
            P_SB_C1: begin
               p1_ff <= alu_prod;
               alu_start_ff <= 1'b1; alu_op_ff <= DP_MUL;
               alu_x_ff <= bn_ff; alu_y_ff <= ad_ff;
               state_ff <= P_WAIT; ret_ff <= P_SB_CMP;
            end
            P_SB_CMP: begin
               // big_a_ff is set when a is bigger
               if (aw_ff != bw_ff) begin
                  big_a_ff <= aw_ff > bw_ff;
                  state_ff <= P_SB_BCMP;
               end else if (p1_ff == alu_prod) begin
                  fault_ff <= FAULT_NONE;
                  rp_ff <= 1'b1; rw_ff <= '0; rn_ff <= '0; rd_ff <= word_type'(1);
                  state_ff <= P_DONE;
               end else begin
                  big_a_ff <= p1_ff > alu_prod;
                  state_ff <= P_SB_BCMP;
               end
               // clear u and g
               u_ff <= '0;
               g_ff <= '0;
            end
            P_SB_BCMP: begin
               // borrow: big.n*small.d < small.n*big.d; with a big that is p1 < p2
               // recompute both products in proper order
               alu_start_ff <= 1'b1; alu_op_ff <= DP_MUL;
               alu_x_ff <= an_ff; alu_y_ff <= bd_ff;
               state_ff <= P_WAIT; ret_ff <= P_SB_B1;
            end
            P_SB_B1: begin
               p1_ff <= alu_prod;
               alu_start_ff <= 1'b1; alu_op_ff <= DP_MUL;
               alu_x_ff <= bn_ff; alu_y_ff <= ad_ff;
               state_ff <= P_WAIT; ret_ff <= P_SB_B2;
            end
            P_SB_B2: begin
               // t = big.n*small.d, u = small.n*big.d
               if (big_a_ff) begin
                  t_ff <= p1_ff[W-1:0]; u_ff <= plo;
                  g_ff <= word_type'(p1_ff < alu_prod);
                  rp_ff <= ap_ff;
                  rw_ff <= aw_ff - bw_ff;
               end else begin
                  t_ff <= plo; u_ff <= p1_ff[W-1:0];
                  g_ff <= word_type'(alu_prod < p1_ff);
                  rp_ff <= bp_ff;
                  rw_ff <= bw_ff - aw_ff;
               end
               alu_start_ff <= 1'b1; alu_op_ff <= DP_MUL;
               alu_x_ff <= ad_ff; alu_y_ff <= bd_ff;
               state_ff <= P_WAIT; ret_ff <= P_SB_FIN;
            end
            P_SB_FIN: begin
               rd_ff <= plo;
               rw_ff <= rw_ff - g_ff;
               rn_ff <= (g_ff[0] ? plo : '0) + t_ff - u_ff;
               state_ff <= P_NR_CHK;
            end
            // ---- multiply (also divide, after b is inverted): n = bw*an*bd + aw*bn*ad + an*bn
            P_M_W: begin
               rw_ff <= plo;
               rp_ff <= (ap_ff == bp_ff);
               alu_start_ff <= 1'b1; alu_op_ff <= DP_MUL;
               alu_x_ff <= bw_ff; alu_y_ff <= an_ff;
               state_ff <= P_WAIT; ret_ff <= P_M_T1;
            end
            P_M_T1: begin
               alu_start_ff <= 1'b1; alu_op_ff <= DP_MUL;
               alu_x_ff <= plo; alu_y_ff <= bd_ff;
               state_ff <= P_WAIT; ret_ff <= P_M_T2;
            end
            P_M_T2: begin
               t_ff <= plo;
               alu_start_ff <= 1'b1; alu_op_ff <= DP_MUL;
               alu_x_ff <= aw_ff; alu_y_ff <= bn_ff;
               state_ff <= P_WAIT; ret_ff <= P_M_T3;
            end
            P_M_T3: begin
               alu_start_ff <= 1'b1; alu_op_ff <= DP_MUL;
               alu_x_ff <= plo; alu_y_ff <= ad_ff;
               state_ff <= P_WAIT; ret_ff <= P_M_T4;
            end
            P_M_T4: begin
               t_ff <= t_ff + plo;
               alu_start_ff <= 1'b1; alu_op_ff <= DP_MUL;
               alu_x_ff <= an_ff; alu_y_ff <= bn_ff;
               state_ff <= P_WAIT; ret_ff <= P_M_T5;
            end
            P_M_T5: begin
               rn_ff <= t_ff + plo;
               alu_start_ff <= 1'b1; alu_op_ff <= DP_MUL;
               alu_x_ff <= ad_ff; alu_y_ff <= bd_ff;
               state_ff <= P_WAIT; ret_ff <= P_M_D;
            end
            P_M_D: begin
               rd_ff <= plo;
               state_ff <= P_NR_CHK;
            end
            // ---- normalise result
            P_NR_CHK: begin
               if (rd_ff == '0) begin
                  fault_ff <= FAULT_DEN_WRAP;
                  state_ff <= P_DONE;
               end else begin
                  alu_start_ff <= 1'b1; alu_op_ff <= DP_DIV;
                  alu_x_ff <= rn_ff; alu_y_ff <= rd_ff;
                  state_ff <= P_WAIT; ret_ff <= P_NR_DIV;
               end
            end
            P_NR_DIV: begin
               rw_ff <= rw_ff + alu_quot;
               rn_ff <= alu_rem;
               alu_start_ff <= 1'b1; alu_op_ff <= DP_GCD;
               alu_x_ff <= alu_rem; alu_y_ff <= rd_ff;
               state_ff <= P_WAIT; ret_ff <= P_NR_GCD;
            end
            P_NR_GCD: begin
               g_ff <= alu_gcd;
               if (alu_gcd > word_type'(1)) begin
                  alu_start_ff <= 1'b1; alu_op_ff <= DP_DIV;
                  alu_x_ff <= rn_ff; alu_y_ff <= alu_gcd;
                  state_ff <= P_WAIT; ret_ff <= P_NR_DN;
               end else begin
                  state_ff <= P_DONE;
               end
            end
            P_NR_DN: begin
               rn_ff <= alu_quot;
               alu_start_ff <= 1'b1; alu_op_ff <= DP_DIV;
               alu_x_ff <= rd_ff; alu_y_ff <= g_ff;
               state_ff <= P_WAIT; ret_ff <= P_NR_DD;
            end
            P_NR_DD: begin
               rd_ff <= alu_quot;
               state_ff <= P_DONE;
            end
            P_DONE: begin
               rsp_valid <= 1'b1;
               if (fault_ff != FAULT_NONE || (rw_ff == '0 && rn_ff == '0)) begin
                  rsp_r_positive <= 1'b1;
                  rsp_r_integer_part <= '0;
                  rsp_r_frac_top <= '0;
                  rsp_r_frac_bottom <= FieldWidth'(1);
               end else begin
                  rsp_r_positive <= rp_ff;
                  rsp_r_integer_part <= out32(rw_ff);
                  rsp_r_frac_top <= out32(rn_ff);
                  rsp_r_frac_bottom <= out32(rd_ff);
               end
               rsp_fault <= fault_ff;
               state_ff <= P_IDLE;
            end
            default: state_ff <= P_IDLE;
         endcase
      end
   end
endmodule

FILE: src/mra_checker.sv
`timescale 1ns / 1ps
module mra_checker
   import mra_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_r_positive,
   input logic [FieldWidth-1:0] rsp_r_integer_part,
   input logic [FieldWidth-1:0] rsp_r_frac_top,
   input logic [FieldWidth-1:0] rsp_r_frac_bottom,
   input logic [1:0]            rsp_fault
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_r_frac_top)
         && $stable(rsp_fault))
      else $error("result changed while stalled");
   a_fault_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fault != FAULT_NONE |-> rsp_r_positive
         && rsp_r_integer_part == '0 && rsp_r_frac_top == '0
         && rsp_r_frac_bottom == FieldWidth'(1))
      else $error("faulted result not cleared");
   a_proper: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_r_frac_top < rsp_r_frac_bottom
         && rsp_fault != 2'd3)
      else $error("improper fraction or bad fault code");
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while busy");
endmodule

bind mixed_rational_arith_unit_core mra_checker u_mra_checker (.*);
